/* rtl/core/lss_pkg.sv */
// ----------------------------------------------------------------------------
// lss_pkg: shared definitions for the bounded stack with search
// Command and status codes, field widths and the default stack depth.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned DataWidth    = 32;
  localparam int unsigned PosWidth     = 6;
  localparam int unsigned OccWidth     = 7;

  typedef enum logic [1:0] {
    CmdPush   = 2'd0,
    CmdPop    = 2'd1,
    CmdPeek   = 2'd2,
    CmdSearch = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StUnder = 2'd1,
    StOver  = 2'd2
  } status_e;

endpackage

/* rtl/core/lss_stack_ram.sv */
// ----------------------------------------------------------------------------
// lss_stack_ram: stack word storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lss_stack_ram
  import lss_pkg::*;
#(
  parameter int unsigned Depth = DefaultDepth,
  localparam int unsigned AddrWidth = $clog2(Depth)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrWidth-1:0]        waddr_i,
  input  logic signed [DataWidth-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AddrWidth-1:0]        raddr_i,
  output logic signed [DataWidth-1:0] rdata_o
);

  logic signed [DataWidth-1:0] mem_q [Depth];
  logic signed [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/lifo_stack_with_search_unit.sv */
// ----------------------------------------------------------------------------
// lifo_stack_with_search_unit: bounded LIFO stack with top-down search
// Push, pop, peek and search on signed 32-bit words held in a RAM with one write and one read port.
//
//   channel  | signals                                        | direction
//   ---------+------------------------------------------------+----------
//   request  | start_i, busy_o, command_i, operand_value_i    | in, busy_o out
//   result   | done_o, status_o, read_value_o, found_o,       | out
//            | position_from_top_o, stack_empty_o, occupancy_o|
//
// push, and any request that ends in underflow, overflow or an empty search,
// gives its result in the cycle after acceptance; a new request can be taken then.
// pop and peek do one RAM read of the top word and take it in the read state.
// search compares from the top down and stops at the first hit or, on a miss, after
// the bottom word; the one RAM read port and the word compare handle one entry per cycle.
// reset clears the sequencer state, the entry count and done_o only; words are never read before written.
// done_o is high for one cycle per request; the receiver cannot stall.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_unit
  import lss_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  command_i,
  input  logic signed [DataWidth-1:0] operand_value_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic signed [DataWidth-1:0] read_value_o,
  output logic                        found_o,
  output logic [PosWidth-1:0]         position_from_top_o,
  output logic                        stack_empty_o,
  output logic [OccWidth-1:0]         occupancy_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]                  state_q, state_d;
  cmd_e                        cmd_q, cmd_d;
  logic signed [DataWidth-1:0] value_q, value_d;
  logic [CW-1:0]               count_q, count_d;
  logic [AW-1:0]               scan_addr_q, scan_addr_d;
  logic [AW-1:0]               pos_q, pos_d;

  logic                        done_q, done_d;
  status_e                     status_q, status_d;
  logic signed [DataWidth-1:0] rd_q, rd_d;
  logic                        found_q, found_d;
  logic [AW-1:0]               hit_pos_q, hit_pos_d;

  logic                        accept;
  logic                        full;
  logic                        empty;
  logic [AW-1:0]               top_addr;
  logic                        ram_we;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic signed [DataWidth-1:0] ram_rdata;

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign full     = (count_q == FullCount);
  assign empty    = (count_q == '0);
  assign top_addr = AW'(count_q - CW'(1));

  lss_stack_ram #(
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (operand_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    value_d     = value_q;
    count_d     = count_q;
    scan_addr_d = scan_addr_q;
    pos_d       = pos_q;
    done_d      = 1'b0;
    status_d    = status_q;
    rd_d        = rd_q;
    found_d     = found_q;
    hit_pos_d   = hit_pos_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = top_addr;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d     = cmd_e'(command_i);
          value_d   = operand_value_i;
          status_d  = StOk;
          rd_d      = '0;
          found_d   = 1'b0;
          hit_pos_d = '0;
          unique case (cmd_e'(command_i))
            CmdPush: begin
              done_d = 1'b1;
              if (full) begin
                status_d = StOver;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            CmdPop, CmdPeek: begin
              if (empty) begin
                done_d   = 1'b1;
                status_d = StUnder;
              end else begin
                ram_re  = 1'b1;
                state_d = S_READ;
              end
            end
            CmdSearch: begin
              if (empty) begin
                done_d = 1'b1;
              end else begin
                ram_re      = 1'b1;
                scan_addr_d = top_addr;
                pos_d       = '0;
                state_d     = S_SCAN;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        done_d  = 1'b1;
        rd_d    = ram_rdata;
        state_d = S_IDLE;
        if (cmd_q == CmdPop) begin
          count_d = count_q - CW'(1);
        end
      end
      S_SCAN: begin
        // read data holds the word at scan_addr_q, pos_q below the top
        if (ram_rdata == value_q) begin
          done_d    = 1'b1;
          found_d   = 1'b1;
          hit_pos_d = pos_q;
          state_d   = S_IDLE;
        end else if (scan_addr_q == '0) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ram_re      = 1'b1;
          ram_raddr   = scan_addr_q - AW'(1);
          scan_addr_d = scan_addr_q - AW'(1);
          pos_d       = pos_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    value_q     <= value_d;
    scan_addr_q <= scan_addr_d;
    pos_q       <= pos_d;
    status_q    <= status_d;
    rd_q        <= rd_d;
    found_q     <= found_d;
    hit_pos_q   <= hit_pos_d;
  end

  assign done_o              = done_q;
  assign status_o            = status_q;
  assign read_value_o        = rd_q;
  assign found_o             = found_q;
  assign position_from_top_o = PosWidth'(hit_pos_q);
  assign stack_empty_o       = empty;
  assign occupancy_o         = OccWidth'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("entry count above depth");

  a_write_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE) && !full)
    else $error("stack write outside idle or onto full stack");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while sequencer still busy");

  a_busy_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !$past(busy_o)) |-> $past(start_i))
    else $error("sequencer left idle without a request");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> done_o)
    else $error("entry count changed without a result");

endmodule
